// ----- rtl/core/aps_pkg.sv -----
// Shared types and codes for the aging priority scheduler.
package aps_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] ST_RAN    = 3'd0;
    localparam logic [2:0] ST_FINISH = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    localparam logic [1:0] CFG_RUN_PENALTY = 2'd0;
    localparam logic [1:0] CFG_WAIT_BONUS  = 2'd1;

    localparam logic [7:0] RUN_PENALTY_RST = 8'd3;
    localparam logic [7:0] WAIT_BONUS_RST  = 8'd1;

    typedef logic [2:0] t_status;
    typedef logic [1:0] t_cfg_idx;

    // One process record as held in the slot memory.
    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] prio;
        logic [31:0] arrival;
        logic [15:0] remaining;
        logic [15:0] used;
        logic [15:0] waited;
        logic [15:0] streak;
    } t_entry;

endpackage

// ----- rtl/core/aging_priority_scheduler.sv -----
// Aging priority scheduler: slot memory, scan/age/compact sequencer and shared aging unit.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------------
//  command   | start / busy           | i_op, i_proc_id, i_start_priority, i_arrival_tick,
//            |                        | i_total_ticks
//  result    | o_valid (1-cycle beat) | o_status, o_run_id, o_finish_tick, o_finish_arrival,
//            |                        | o_finish_used, o_final_priority
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// An insert answers on the next cycle and leaves busy low. A tick holds busy for a scan
// pass and an aging pass over the live entries, plus a pass that compacts the later
// entries when the winner retires; the result beat comes in the cycle busy drops.
// Reset: synchronous, active low; the table is tracked by a fill count, so no clearing
// pass is needed and the block takes a command as soon as reset is released.
// Stalls: the receiver cannot stall; each result is shown for exactly one cycle.
module aging_priority_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_op,
    input  logic [7:0]             i_proc_id,
    input  logic signed [15:0]     i_start_priority,
    input  logic [31:0]            i_arrival_tick,
    input  logic [15:0]            i_total_ticks,
    input  logic                   i_cfg_we,
    input  aps_pkg::t_cfg_idx      i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    output logic                   o_valid,
    output aps_pkg::t_status       o_status,
    output logic [7:0]             o_run_id,
    output logic [31:0]            o_finish_tick,
    output logic [31:0]            o_finish_arrival,
    output logic [15:0]            o_finish_used,
    output logic signed [15:0]     o_final_priority
);
    import aps_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_AGE   = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    // slot memory: entries 0 .. r_count-1 are live, in insertion order
    t_entry r_mem [SLOTS];

    logic [1:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_addr;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    t_entry            r_rd_data;
    logic              r_pick_vld;
    logic [IW-1:0]     r_pick_idx;
    logic signed [15:0] r_best;
    t_entry            r_pk;
    logic [31:0]       r_now;
    logic [7:0]        r_pen;
    logic [7:0]        r_bonus;
    logic              r_valid;
    t_status           r_status;
    logic [7:0]        r_run_id;
    logic [31:0]       r_fin_tick;
    logic [31:0]       r_fin_arr;
    logic [15:0]       r_fin_used;
    logic [15:0]       r_fin_prio;

    logic              w_accept;
    logic              w_issue;
    logic              w_drained;
    logic              w_arrived;
    logic              w_better;
    logic              w_is_pick;
    logic signed [17:0] w_delta;
    logic signed [17:0] w_sum;
    logic [15:0]       w_prio_sat;
    t_entry            w_aged;
    t_entry            w_new;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    t_entry            w_wr_data;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_issue   = busy && (r_addr < r_count);
    assign w_drained = !r_rd_vld && (r_addr == r_count);

    // selection compare on the registered read beat
    assign w_arrived = (r_rd_data.arrival <= r_now);
    assign w_better  = !r_pick_vld || ($signed(r_rd_data.prio) > r_best);
    assign w_is_pick = r_pick_vld && (r_rd_idx == r_pick_idx);

    // shared aging unit: one signed add with saturation per entry
    always_comb begin
        w_delta = w_is_pick ? -$signed({10'b0, r_pen}) : $signed({10'b0, r_bonus});
        w_sum   = $signed({{2{r_rd_data.prio[15]}}, r_rd_data.prio}) + w_delta;
        priority if (w_sum > 18'sd32767) begin
            w_prio_sat = 16'h7FFF;
        end else if (w_sum < -18'sd32768) begin
            w_prio_sat = 16'h8000;
        end else begin
            w_prio_sat = w_sum[15:0];
        end
        w_aged = r_rd_data;
        w_aged.prio = w_prio_sat;
        if (w_is_pick) begin
            w_aged.remaining = (r_rd_data.remaining == 16'd0) ? 16'd0
                                                              : r_rd_data.remaining - 16'd1;
            w_aged.used   = (&r_rd_data.used) ? r_rd_data.used : r_rd_data.used + 16'd1;
            w_aged.streak = (&r_rd_data.streak) ? r_rd_data.streak : r_rd_data.streak + 16'd1;
            w_aged.waited = 16'd0;
        end else begin
            w_aged.waited = (&r_rd_data.waited) ? r_rd_data.waited : r_rd_data.waited + 16'd1;
            w_aged.streak = 16'd0;
        end
    end

    always_comb begin
        w_new.pid       = i_proc_id;
        w_new.prio      = i_start_priority;
        w_new.arrival   = i_arrival_tick;
        w_new.remaining = i_total_ticks;
        w_new.used      = 16'd0;
        w_new.waited    = 16'd0;
        w_new.streak    = 16'd0;
    end

    // single write port: append on insert, write back while aging, move down while compacting
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[IW-1:0];
        w_wr_data = w_new;
        unique case (r_state)
            S_IDLE: begin
                w_wr_en = w_accept && (i_op == OP_INSERT) && (r_count != FULL_CNT);
            end
            S_AGE: begin
                w_wr_en   = r_rd_vld;
                w_wr_addr = r_rd_idx;
                w_wr_data = w_aged;
            end
            S_SHIFT: begin
                w_wr_en   = r_rd_vld;
                w_wr_addr = r_rd_idx - 1'b1;
                w_wr_data = r_rd_data;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_pick_vld <= 1'b0;
            r_now      <= 32'd0;
            r_pen      <= RUN_PENALTY_RST;
            r_bonus    <= WAIT_BONUS_RST;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RUN_PENALTY) begin
                    r_pen <= i_cfg_data;
                end else if (i_cfg_idx == CFG_WAIT_BONUS) begin
                    r_bonus <= i_cfg_data;
                end
            end

            // read pipeline: advance the address, tag the beat in the following cycle
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_rd_idx <= r_addr[IW-1:0];
                r_addr   <= r_addr + 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_op == OP_INSERT) begin
                            r_valid          <= 1'b1;
                            r_run_id         <= 8'd0;
                            r_fin_tick       <= 32'd0;
                            r_fin_arr        <= 32'd0;
                            r_fin_used       <= 16'd0;
                            r_fin_prio       <= 16'd0;
                            if (r_count == FULL_CNT) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_INSERT;
                                r_count  <= r_count + 1'b1;
                            end
                        end else begin
                            r_state    <= S_SCAN;
                            r_addr     <= '0;
                            r_pick_vld <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    // keep the first arrived entry of highest priority
                    if (r_rd_vld && w_arrived && w_better) begin
                        r_pick_vld <= 1'b1;
                        r_pick_idx <= r_rd_idx;
                        r_best     <= $signed(r_rd_data.prio);
                    end
                    if (w_drained) begin
                        r_state <= S_AGE;
                        r_addr  <= '0;
                    end
                end
                S_AGE: begin
                    if (r_rd_vld && w_is_pick) begin
                        r_pk <= w_aged;
                    end
                    if (w_drained) begin
                        r_now      <= r_now + 32'd1;
                        r_fin_tick <= 32'd0;
                        r_fin_arr  <= 32'd0;
                        r_fin_used <= 16'd0;
                        if (!r_pick_vld) begin
                            r_status   <= ST_IDLE;
                            r_run_id   <= 8'd0;
                            r_fin_prio <= 16'd0;
                            r_valid    <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_run_id   <= r_pk.pid;
                            r_fin_prio <= r_pk.prio;
                            if (r_pk.remaining == 16'd0) begin
                                // retire: report now, strobe after the table is compacted
                                r_status   <= ST_FINISH;
                                r_fin_tick <= r_now + 32'd1;
                                r_fin_arr  <= r_pk.arrival;
                                r_fin_used <= r_pk.used;
                                r_addr     <= CW'(r_pick_idx) + CW'(1);
                                r_state    <= S_SHIFT;
                            end else begin
                                r_status <= ST_RAN;
                                r_valid  <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                    end
                end
                S_SHIFT: begin
                    if (w_drained) begin
                        r_count <= r_count - 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_run_id         = r_run_id;
    assign o_finish_tick    = r_fin_tick;
    assign o_finish_arrival = r_fin_arr;
    assign o_finish_used    = r_fin_used;
    assign o_final_priority = $signed(r_fin_prio);

endmodule

// ----- rtl/core/aps_checker.sv -----
// Port-level assertions for the aging priority scheduler, bound to the top level.
module aps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_op,
    input logic              o_valid,
    input aps_pkg::t_status  o_status,
    input logic [7:0]        o_run_id,
    input logic [15:0]       o_final_priority
);
    import aps_pkg::*;

    // an insert beat answers on the very next cycle
    a_insert_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_op == OP_INSERT) |=> o_valid)
        else $error("insert not answered in one cycle");

    // a tick beat occupies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_op == OP_TICK) |=> busy && !o_valid)
        else $error("tick did not raise busy");

    // results are only shown once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_FULL))
        else $error("status code out of range");

    // no entry ran: run fields are zero
    a_no_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_IDLE || o_status == ST_INSERT || o_status == ST_FULL)
        |-> (o_run_id == 8'd0) && (o_final_priority == 16'd0))
        else $error("run fields set without a run");

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_op             (i_op),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_run_id         (o_run_id),
    .o_final_priority (o_final_priority)
);

// ----- bench/aging_priority_scheduler_test.sv -----
// Self-checking bench for the aging priority scheduler: directed cases, one long run, random phases.
`timescale 1ns / 100ps

module aging_priority_scheduler_test;
    import aps_pkg::*;

    localparam int SLOTS         = 16;
    // Worst tick: scan, age and compact a full table, plus margin for the result beat.
    localparam int SETTLE_CYCLES = 3 * SLOTS + 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 265;

    // Register indexes past the two real registers; writes there must change nothing.
    localparam t_cfg_idx CFG_SPARE_LO = 2'd2;
    localparam t_cfg_idx CFG_SPARE_HI = 2'd3;

    // One result beat as the scheduler should report it.
    typedef struct packed {
        t_status     status;
        logic [7:0]  run_id;
        logic [31:0] finish_tick;
        logic [31:0] finish_arrival;
        logic [15:0] finish_used;
        logic [15:0] final_priority;
    } t_outcome;

    // Drive every input to a known value from time zero; hold reset low.
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic        i_op             = OP_INSERT;
    logic [7:0]  i_proc_id        = '0;
    logic [15:0] i_start_priority = '0;
    logic [31:0] i_arrival_tick   = '0;
    logic [15:0] i_total_ticks    = '0;
    logic        i_cfg_we         = 1'b0;
    t_cfg_idx    i_cfg_idx        = CFG_RUN_PENALTY;
    logic [7:0]  i_cfg_data       = '0;
    logic        o_valid;
    t_status     o_status;
    logic [7:0]  o_run_id;
    logic [31:0] o_finish_tick;
    logic [31:0] o_finish_arrival;
    logic [15:0] o_finish_used;
    logic [15:0] o_final_priority;

    // Shadow of the process table, kept in insertion order as a filled prefix.
    logic [7:0]  tbl_pid       [SLOTS];
    int          tbl_prio      [SLOTS];
    logic [31:0] tbl_arrival   [SLOTS];
    int          tbl_remaining [SLOTS];
    int          tbl_used      [SLOTS];
    int          tbl_count   = 0;
    logic [31:0] sched_now   = '0;
    logic [7:0]  cur_penalty = RUN_PENALTY_RST;
    logic [7:0]  cur_bonus   = WAIT_BONUS_RST;

    // Outcomes of accepted commands whose result beat has not arrived yet, oldest first.
    t_outcome    pending_outcomes[$];
    int          fail_count = 0;

    aging_priority_scheduler #(.SLOTS(SLOTS)) dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; sized well past the slowest correct run.
    initial begin
        #(60_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_prio(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Apply one accepted command to the shadow table and return the beat it must produce.
    function automatic t_outcome step_scheduler(input logic op, input logic [7:0] pid,
                                                input logic [15:0] prio,
                                                input logic [31:0] arrival,
                                                input logic [15:0] total);
        t_outcome res;
        int       pick;
        int       i;
        res = '0;
        if (op == OP_INSERT) begin
            if (tbl_count == SLOTS) begin
                res.status = ST_FULL;
            end else begin
                tbl_pid[tbl_count]       = pid;
                tbl_prio[tbl_count]      = int'($signed(prio));
                tbl_arrival[tbl_count]   = arrival;
                tbl_remaining[tbl_count] = int'(total);
                tbl_used[tbl_count]      = 0;
                tbl_count++;
                res.status = ST_INSERT;
            end
        end else begin
            // Pick the highest priority among arrived entries; the earliest wins a tie.
            pick = -1;
            for (i = 0; i < tbl_count; i++) begin
                if (tbl_arrival[i] <= sched_now && (pick < 0 || tbl_prio[i] > tbl_prio[pick]))
                    pick = i;
            end
            // Age the table: charge the runner, reward everyone else.
            for (i = 0; i < tbl_count; i++) begin
                if (i == pick) begin
                    if (tbl_remaining[i] > 0) tbl_remaining[i]--;
                    tbl_prio[i] = clamp_prio(tbl_prio[i] - int'(cur_penalty));
                    if (tbl_used[i] < 65535) tbl_used[i]++;
                end else begin
                    tbl_prio[i] = clamp_prio(tbl_prio[i] + int'(cur_bonus));
                end
            end
            sched_now = sched_now + 32'd1;
            if (pick < 0) begin
                res.status = ST_IDLE;
            end else begin
                res.run_id         = tbl_pid[pick];
                res.final_priority = 16'(tbl_prio[pick]);
                if (tbl_remaining[pick] == 0) begin
                    res.status         = ST_FINISH;
                    res.finish_tick    = sched_now;
                    res.finish_arrival = tbl_arrival[pick];
                    res.finish_used    = 16'(tbl_used[pick]);
                    // Retire: slide later entries down one slot, keeping their order.
                    for (i = pick; i < tbl_count - 1; i++) begin
                        tbl_pid[i]       = tbl_pid[i + 1];
                        tbl_prio[i]      = tbl_prio[i + 1];
                        tbl_arrival[i]   = tbl_arrival[i + 1];
                        tbl_remaining[i] = tbl_remaining[i + 1];
                        tbl_used[i]      = tbl_used[i + 1];
                    end
                    tbl_count--;
                end else begin
                    res.status = ST_RAN;
                end
            end
        end
        return res;
    endfunction

    // Present one command beat and hold it until the block takes it. Leave start high on
    // return so a following beat goes out back to back; callers that wait drop it first.
    task automatic issue(input logic op, input logic [7:0] pid, input logic [15:0] prio,
                         input logic [31:0] arrival, input logic [15:0] total);
        start            <= 1'b1;
        i_op             <= op;
        i_proc_id        <= pid;
        i_start_priority <= prio;
        i_arrival_tick   <= arrival;
        i_total_ticks    <= total;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_outcomes.push_back(step_scheduler(op, pid, prio, arrival, total));
    endtask

    task automatic insert_proc(input logic [7:0] pid, input logic [15:0] prio,
                               input logic [31:0] arrival, input logic [15:0] total);
        issue(OP_INSERT, pid, prio, arrival, total);
    endtask

    // Payload is ignored on a tick; fill it with noise anyway.
    task automatic tick_once();
        issue(OP_TICK, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every outstanding beat is back, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only ever called with the block idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_RUN_PENALTY: cur_penalty = val;
            CFG_WAIT_BONUS:  cur_bonus   = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_weights(input logic [7:0] penalty, input logic [7:0] bonus);
        write_reg(CFG_RUN_PENALTY, penalty);
        write_reg(CFG_WAIT_BONUS, bonus);
    endtask

    // Tick until the shadow table is empty; every entry here must arrive eventually.
    task automatic run_until_empty();
        while (tbl_count != 0) tick_once();
    endtask

    // Ticks on an empty table are idle but still advance time.
    task automatic test_idle_ticks();
        tick_once();
        tick_once();
    endtask

    // Equal priorities: a not-yet-arrived head is skipped, then the earliest arrived runs.
    task automatic test_arrival_and_ties();
        insert_proc(8'h01, 16'd5, sched_now + 32'd2, 16'd2);
        insert_proc(8'h02, 16'd5, 32'd0, 16'd1);
        insert_proc(8'h03, 16'd5, sched_now, 16'd1);
        run_until_empty();
    endtask

    // An entry with no service retires the first time it runs, having used one tick.
    task automatic test_zero_service();
        insert_proc(8'h04, 16'hFFFF, 32'd0, 16'd0);
        insert_proc(8'h05, 16'hFFFF, 32'd0, 16'd1);
        run_until_empty();
    endtask

    // Writes to spare indexes must leave the reset weights in force.
    task automatic test_spare_index();
        drain();
        write_reg(CFG_SPARE_LO, 8'h00);
        write_reg(CFG_SPARE_HI, 8'hFF);
        insert_proc(8'h10, 16'd100, 32'd0, 16'd2);
        insert_proc(8'h11, 16'd99, 32'd0, 16'd1);
        run_until_empty();
    endtask

    // Drive priorities into both rails, then check a frozen tie with no aging at all.
    task automatic test_saturation();
        drain();
        set_weights(8'hFF, 8'hFF);
        insert_proc(8'hAA, 16'h8064, 32'd0, 16'd3);             // -32668
        insert_proc(8'h55, 16'h7F9B, sched_now + 32'd3, 16'd1); // 32667, arrives late
        run_until_empty();
        drain();
        set_weights(8'h00, 8'h00);
        insert_proc(8'h5A, 16'd7, 32'd0, 16'd2);
        insert_proc(8'hA5, 16'd7, 32'd0, 16'd2);
        run_until_empty();
        drain();
        set_weights(RUN_PENALTY_RST, WAIT_BONUS_RST);
    endtask

    // Fill every slot, bounce one more insert off the full table, then empty it.
    task automatic test_table_full();
        int i;
        for (i = 0; i <= SLOTS; i++)
            insert_proc(8'(8'h20 + i), 16'($urandom_range(0, 3)), sched_now, 16'd1);
        run_until_empty();
    endtask

    // One entry with a long service need, run to completion back to back.
    task automatic test_long_service();
        insert_proc(8'hFF, 16'd0, 32'd0, 16'd40);
        run_until_empty();
    endtask

    // Park an entry that never arrives; it stays in the table for the rest of the run
    // and keeps aging toward the top rail.
    task automatic test_never_arrives();
        insert_proc(8'h80, 16'h7FFF, 32'hFFFF_FFFF, 16'hFFFF);
        tick_once();
    endtask

    // Random traffic in phases, each under its own weights. Keep the table busy so
    // ties, late arrivals, retirements and a full table all come up often.
    task automatic test_random_phases();
        int          phase;
        int          n;
        int          gap_odds;
        int          insert_odds;
        logic [15:0] prio;
        logic [31:0] arrival;
        logic [15:0] total;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            case (phase)
                0: set_weights(8'h00, 8'h00);
                1: set_weights(8'hFF, 8'hFF);
                2: set_weights(8'h00, 8'hFF);
                3: set_weights(8'hFF, 8'h00);
                4: set_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: set_weights(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
            endcase
            // No sender gaps in the third phase and in the closing one.
            if (phase == 2 || phase == RANDOM_PHASES - 1) gap_odds = 0;
            else gap_odds = $urandom_range(10, 40);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < gap_odds) pause_sender($urandom_range(1, 13));
                // The parked entry always holds one slot.
                if (tbl_count <= 1) insert_odds = 75;
                else if (tbl_count >= SLOTS) insert_odds = 10;
                else insert_odds = 40;
                if ($urandom_range(0, 99) < insert_odds) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: prio = 16'($urandom_range(0, 6)) - 16'd3;
                        5, 6, 7:       prio = 16'($urandom);
                        8:             prio = 16'h7FFF - 16'($urandom_range(0, 300));
                        default:       prio = 16'h8000 + 16'($urandom_range(0, 300));
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5, 6: arrival = sched_now + $urandom_range(0, 3);
                        7, 8:                arrival = $urandom_range(0, sched_now);
                        default:             arrival = sched_now + $urandom_range(4, 40);
                    endcase
                    if ($urandom_range(0, 9) == 0) total = 16'($urandom_range(7, 40));
                    else total = 16'($urandom_range(1, 6));
                    insert_proc(8'($urandom), prio, arrival, total);
                end else begin
                    tick_once();
                end
            end
        end
    endtask

    // Check every result beat against the oldest outstanding outcome.
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing outstanding: status %0d", o_status);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_run_id !== want.run_id) begin
                    $error("run_id: expected %0d, actual %0d", want.run_id, o_run_id);
                    fail_count++;
                end
                if (o_finish_tick !== want.finish_tick) begin
                    $error("finish_tick: expected %0d, actual %0d",
                           want.finish_tick, o_finish_tick);
                    fail_count++;
                end
                if (o_finish_arrival !== want.finish_arrival) begin
                    $error("finish_arrival: expected %0d, actual %0d",
                           want.finish_arrival, o_finish_arrival);
                    fail_count++;
                end
                if (o_finish_used !== want.finish_used) begin
                    $error("finish_used: expected %0d, actual %0d",
                           want.finish_used, o_finish_used);
                    fail_count++;
                end
                if (o_final_priority !== want.final_priority) begin
                    $error("final_priority: expected %0d, actual %0d",
                           $signed(want.final_priority), $signed(o_final_priority));
                    fail_count++;
                end
            end
        end else if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            $error("o_valid: expected 0 or 1, actual %b", o_valid);
            fail_count++;
        end
    end

    initial begin
        // Hold reset from time zero, then release it; it is never asserted again.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_arrival_and_ties();
        test_zero_service();
        test_spare_index();
        test_saturation();
        test_table_full();
        test_long_service();
        test_never_arrives();
        test_random_phases();

        // Drop start, give the last beats a bounded window, then let the block settle.
        start <= 1'b0;
        repeat (SETTLE_CYCLES * 4) begin
            if (pending_outcomes.size() != 0) @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $error("%0d result beats never arrived", pending_outcomes.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- aging_priority_scheduler.f -----
rtl/core/aps_pkg.sv
rtl/core/aging_priority_scheduler.sv
rtl/core/aps_checker.sv
bench/aging_priority_scheduler_test.sv
